// ===== rtl/bsti_pkg.sv =====
package bsti_pkg;

  localparam int KEY_W  = 32;
  localparam int SLOT_W = 10;

  typedef enum logic [1:0] {
    F_INSERT = 2'd0,
    F_READ   = 2'd1,
    F_CLEAR  = 2'd2,
    F_NOP    = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_DUP      = 2'd1,
    ST_NOROOM   = 2'd2,
    ST_DONE     = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLR,
    S_CMP,
    S_RD,
    S_DONE
  } state_t;

  typedef struct packed {
    logic             used;
    logic [KEY_W-1:0] key;
  } entry_t;

  typedef struct packed {
    status_t                 status;
    logic [SLOT_W-1:0]       slot;
    logic signed [KEY_W-1:0] value;
    logic                    occupied;
  } res_t;

endpackage

// ===== rtl/bsti_in_if.sv =====
interface bsti_in_if;
  logic                                     valid;
  logic                                     ready;
  logic [1:0]                               func;
  logic signed [bsti_pkg::KEY_W-1:0]        key;
  logic [bsti_pkg::SLOT_W-1:0]              slot_index;

  modport source (output valid, output func, output key, output slot_index, input ready);
  modport sink   (input valid, input func, input key, input slot_index, output ready);
endinterface

// ===== rtl/bsti_out_if.sv =====
interface bsti_out_if;
  logic                                     valid;
  logic                                     ready;
  logic [1:0]                               status;
  logic [bsti_pkg::SLOT_W-1:0]              slot;
  logic signed [bsti_pkg::KEY_W-1:0]        value;
  logic                                     occupied;

  modport source (output valid, output status, output slot, output value, output occupied,
                  input ready);
  modport sink   (input valid, input status, input slot, input value, input occupied,
                  output ready);
endinterface

// ===== rtl/bsti_ram.sv =====
module bsti_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/bsti_walk.sv =====
module bsti_walk #(
  parameter int LEVELS = 10
) (
  input  logic                   clk,
  input  logic                   rst_n,
  bsti_in_if.sink                in_ch,
  bsti_out_if.source             out_ch,
  output logic                   mem_we,
  output logic [LEVELS-1:0]      mem_waddr,
  output bsti_pkg::entry_t       mem_wdata,
  output logic                   mem_re,
  output logic [LEVELS-1:0]      mem_raddr,
  input  bsti_pkg::entry_t       mem_rdata
);
  import bsti_pkg::*;

  localparam int AW  = LEVELS;
  localparam int PW  = LEVELS + 1;
  localparam int CAP = (1 << LEVELS) - 1;

  state_t                  state_r, state_nxt;
  logic [PW-1:0]           pos_r, pos_nxt;
  logic [AW-1:0]           clr_r, clr_nxt;
  logic                    clr_emit_r, clr_emit_nxt;
  logic signed [KEY_W-1:0] key_r, key_nxt;
  logic [SLOT_W-1:0]       idx_r, idx_nxt;
  logic                    out_valid_r, out_valid_nxt;
  res_t                    res_r, res_nxt;

  logic          slot_free;
  logic          in_xfer;
  logic          emit;
  res_t          res;
  logic          hit_free;
  logic          hit_eq;
  logic          go_left;
  logic [PW-1:0] child_pos;
  logic          has_room;
  logic          walk_end;
  logic          clr_last;
  logic          idx_in_range;

  assign slot_free    = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = (state_r == S_IDLE);
  assign in_xfer      = in_ch.valid && in_ch.ready;
  assign clr_last     = (clr_r == AW'(CAP - 1));
  assign idx_in_range = (32'(idx_r) < 32'(CAP));

  always_comb begin
    hit_free  = !mem_rdata.used;
    hit_eq    = (mem_rdata.key == key_r);
    go_left   = (key_r < $signed(mem_rdata.key));
    child_pos = {pos_r[PW-2:0], 1'b0} + (go_left ? PW'(1) : PW'(2));
    has_room  = (child_pos < PW'(CAP));
    walk_end  = hit_free || hit_eq || !has_room;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          unique case (func_t'(in_ch.func))
            F_INSERT: state_nxt = S_CMP;
            F_READ:   state_nxt = S_RD;
            F_CLEAR:  state_nxt = S_CLR;
            F_NOP:    state_nxt = S_DONE;
          endcase
        end
      end
      S_CLR: begin
        if (clr_last) begin
          state_nxt = clr_emit_r ? S_DONE : S_IDLE;
        end
      end
      S_CMP: begin
        if (walk_end && slot_free) begin
          state_nxt = S_IDLE;
        end
      end
      S_RD, S_DONE: begin
        if (slot_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    mem_we       = 1'b0;
    mem_waddr    = '0;
    mem_wdata    = '0;
    mem_re       = 1'b0;
    mem_raddr    = '0;
    emit         = 1'b0;
    res          = '0;
    res.status   = ST_DONE;
    pos_nxt      = pos_r;
    clr_nxt      = clr_r;
    clr_emit_nxt = clr_emit_r;
    key_nxt      = key_r;
    idx_nxt      = idx_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          key_nxt = in_ch.key;
          idx_nxt = in_ch.slot_index;
          pos_nxt = '0;
          clr_nxt = '0;
          if (func_t'(in_ch.func) == F_INSERT) begin
            mem_re    = 1'b1;
            mem_raddr = '0;
          end
          if (func_t'(in_ch.func) == F_READ) begin
            mem_re    = 1'b1;
            mem_raddr = AW'(in_ch.slot_index);
          end
          if (func_t'(in_ch.func) == F_CLEAR) begin
            clr_emit_nxt = 1'b1;
          end
        end
      end
      S_CLR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        mem_wdata = '0;
        clr_nxt   = clr_r + AW'(1);
      end
      S_CMP: begin
        priority if (hit_free) begin
          if (slot_free) begin
            mem_we         = 1'b1;
            mem_waddr      = pos_r[AW-1:0];
            mem_wdata.used = 1'b1;
            mem_wdata.key  = key_r;
            emit           = 1'b1;
            res.status     = ST_INSERTED;
            res.slot       = SLOT_W'(pos_r);
            res.value      = key_r;
            res.occupied   = 1'b1;
          end
        end else if (hit_eq) begin
          if (slot_free) begin
            emit         = 1'b1;
            res.status   = ST_DUP;
            res.slot     = SLOT_W'(pos_r);
            res.value    = key_r;
            res.occupied = 1'b1;
          end
        end else if (!has_room) begin
          if (slot_free) begin
            emit       = 1'b1;
            res.status = ST_NOROOM;
          end
        end else begin
          mem_re    = 1'b1;
          mem_raddr = child_pos[AW-1:0];
          pos_nxt   = child_pos;
        end
      end
      S_RD: begin
        if (slot_free) begin
          emit     = 1'b1;
          res.slot = idx_r;
          if (idx_in_range && mem_rdata.used) begin
            res.value    = $signed(mem_rdata.key);
            res.occupied = 1'b1;
          end
        end
      end
      S_DONE: begin
        if (slot_free) begin
          emit         = 1'b1;
          clr_emit_nxt = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    res_nxt       = res_r;
    if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (emit) begin
      out_valid_nxt = 1'b1;
      res_nxt       = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      clr_emit_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      clr_emit_r  <= clr_emit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r <= pos_nxt;
    key_r <= key_nxt;
    idx_r <= idx_nxt;
    res_r <= res_nxt;
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.status   = res_r.status;
  assign out_ch.slot     = res_r.slot;
  assign out_ch.value    = res_r.value;
  assign out_ch.occupied = res_r.occupied;

`ifndef SYNTHESIS
  a_emit_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> (!out_valid_r || out_ch.ready))
    else $error("result produced while a result is still held");

  a_walk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CMP) |-> (pos_r < PW'(CAP)))
    else $error("walk position past the last slot");

  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !mem_we)
    else $error("memory write while idle");

  a_insert_sets_used: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we && state_r == S_CMP) |-> (mem_wdata.used && emit))
    else $error("insert write without used flag or result");

  a_walk_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && func_t'(in_ch.func) == F_INSERT) |=> (state_r == S_CMP && pos_r == '0))
    else $error("insert did not start at the root");
`endif

endmodule

// ===== rtl/array_bst_insert.sv =====
// Binary search tree held in one memory as an implicit array: slot i has
// its children at 2i+1 and 2i+2, 2^LEVELS-1 slots. An insert walks down
// from the root one tree level at a time (one memory read per level);
// duplicate and no-room results take the same walk. A slot read does one
// memory read. A clear writes every slot once. After reset the block runs
// the same clearing pass with in_ch.ready low and produces no result for it.
// One result per item; the next item is taken while a result waits in the
// output register.
module array_bst_insert #(
  parameter int LEVELS = 10
) (
  input logic        clk,
  input logic        rst_n,
  bsti_in_if.sink    in_ch,
  bsti_out_if.source out_ch
);
  import bsti_pkg::*;

  localparam int CAP = (1 << LEVELS) - 1;

  logic              mem_we;
  logic [LEVELS-1:0] mem_waddr;
  entry_t            mem_wdata;
  logic              mem_re;
  logic [LEVELS-1:0] mem_raddr;
  entry_t            mem_rdata;

  bsti_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (CAP)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  bsti_walk #(
    .LEVELS (LEVELS)
  ) u_walk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import bsti_pkg::*;

  localparam int LEVELS      = 10;
  localparam int CAPACITY    = (1 << LEVELS) - 1;
  localparam int ITEMS_TOTAL = 1375;
  localparam int LONG_HOLD   = 600;
  localparam int HOLD_AT     = 300;
  localparam logic signed [KEY_W-1:0] KEY_MIN = {1'b1, {(KEY_W-1){1'b0}}};
  localparam logic signed [KEY_W-1:0] KEY_MAX = {1'b0, {(KEY_W-1){1'b1}}};

  class bst_shadow;
    logic signed [KEY_W-1:0] held_key [CAPACITY];
    bit                      held [CAPACITY];
    bit                      ever_written [CAPACITY];
    int                      written_slots [$];
    int                      live_slots [$];
    res_t                    awaited [$];
    int                      mismatches;

    function new();
      mismatches = 0;
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    function logic signed [KEY_W-1:0] random_held_key();
      return held_key[live_slots[$urandom_range(live_slots.size() - 1)]];
    endfunction

    function logic [SLOT_W-1:0] pick_read_slot();
      int r;
      r = $urandom_range(9);
      if (r == 0 || written_slots.size() == 0) return SLOT_W'(CAPACITY);
      if (r < 6 && live_slots.size() > 0)
        return SLOT_W'(live_slots[$urandom_range(live_slots.size() - 1)]);
      return SLOT_W'(written_slots[$urandom_range(written_slots.size() - 1)]);
    endfunction

    function void note_request(func_t f, logic signed [KEY_W-1:0] k,
                               logic [SLOT_W-1:0] idx);
      res_t r;
      int   pos;
      r.status   = ST_DONE;
      r.slot     = '0;
      r.value    = '0;
      r.occupied = 1'b0;
      case (f)
        F_INSERT: begin
          r.status = ST_NOROOM;
          pos = 0;
          while (pos < CAPACITY) begin
            if (!held[pos]) begin
              held[pos]     = 1'b1;
              held_key[pos] = k;
              live_slots.push_back(pos);
              if (!ever_written[pos]) begin
                ever_written[pos] = 1'b1;
                written_slots.push_back(pos);
              end
              r.status   = ST_INSERTED;
              r.slot     = SLOT_W'(pos);
              r.value    = k;
              r.occupied = 1'b1;
              break;
            end
            if (held_key[pos] == k) begin
              r.status   = ST_DUP;
              r.slot     = SLOT_W'(pos);
              r.value    = k;
              r.occupied = 1'b1;
              break;
            end
            pos = (k < held_key[pos]) ? 2 * pos + 1 : 2 * pos + 2;
          end
        end
        F_READ: begin
          r.slot = idx;
          if (idx < CAPACITY && held[idx]) begin
            r.value    = held_key[idx];
            r.occupied = 1'b1;
          end
        end
        F_CLEAR: begin
          foreach (held[i]) held[i] = 1'b0;
          live_slots.delete();
        end
        default: ;
      endcase
      awaited.push_back(r);
    endfunction

    function void check_response(logic [1:0] st, logic [SLOT_W-1:0] sl,
                                 logic signed [KEY_W-1:0] val, logic occ);
      res_t e;
      if (awaited.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: status %0d slot %0d value %0d occupied %0d",
                   st, sl, val, occ);
        return;
      end
      e = awaited.pop_front();
      if (st !== e.status || sl !== e.slot || val !== e.value || occ !== e.occupied) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch: expected status %0d slot %0d value %0d occupied %0d",
                   e.status, e.slot, e.value, e.occupied);
          $display("          got      status %0d slot %0d value %0d occupied %0d",
                   st, sl, val, occ);
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  bsti_in_if  in_ch ();
  bsti_out_if out_ch ();

  bst_shadow shadow = new;
  bit        sender_steady = 1'b0;
  bit        recv_steady = 1'b0;
  int        items_sent = 0;

  array_bst_insert #(.LEVELS(LEVELS)) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #5 clk = ~clk;

  function automatic int idle_len();
    int r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  function automatic logic signed [KEY_W-1:0] random_key();
    case ($urandom_range(9))
      0:       return KEY_MIN;
      1:       return KEY_MAX;
      2, 3, 4: return KEY_W'(int'($urandom_range(0, 127)) - 64);
      default: return KEY_W'($urandom);
    endcase
  endfunction

  task automatic send_item(input func_t f, input logic signed [KEY_W-1:0] k,
                           input logic [SLOT_W-1:0] idx);
    int gap;
    gap = sender_steady ? 0 : idle_len();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.func       <= f;
    in_ch.key        <= k;
    in_ch.slot_index <= idx;
    do @(posedge clk); while (!in_ch.ready);
    shadow.note_request(f, k, idx);
    if (f != F_NOP) items_sent++;
  endtask

  task automatic send_mixed();
    int r;
    r = $urandom_range(99);
    if (r < 50)
      send_item(F_INSERT, random_key(), SLOT_W'($urandom));
    else if (r < 65)
      send_item(F_INSERT, shadow.live_slots.size() > 0 ? shadow.random_held_key()
                                                       : random_key(),
                SLOT_W'($urandom));
    else if (r < 96)
      send_item(F_READ, KEY_W'($urandom), shadow.pick_read_slot());
    else if (r < 99)
      send_item(F_NOP, KEY_W'($urandom), SLOT_W'($urandom));
    else
      send_item(F_CLEAR, KEY_W'($urandom), SLOT_W'($urandom));
  endtask

  initial begin : result_sink
    int stall_left;
    int taken;
    stall_left = 0;
    taken = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        shadow.check_response(out_ch.status, out_ch.slot, out_ch.value, out_ch.occupied);
        taken++;
        if (taken % 50 == 0) recv_steady = ($urandom_range(3) == 0);
        if (taken == HOLD_AT) stall_left = LONG_HOLD;
        else if (!recv_steady) stall_left = idle_len();
      end
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    int                      n;
    int                      len;
    int                      step;
    bit                      falling;
    logic signed [KEY_W-1:0] base;
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.func       <= F_NOP;
    in_ch.key        <= '0;
    in_ch.slot_index <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    send_item(F_READ, KEY_W'($urandom), SLOT_W'(CAPACITY));
    send_item(F_INSERT, KEY_W'(0), SLOT_W'($urandom));
    send_item(F_INSERT, KEY_MIN, SLOT_W'($urandom));
    send_item(F_INSERT, KEY_MAX, SLOT_W'($urandom));
    send_item(F_INSERT, KEY_W'(-1), SLOT_W'($urandom));
    send_item(F_INSERT, KEY_W'(0), SLOT_W'($urandom));
    send_item(F_INSERT, KEY_MAX, SLOT_W'($urandom));
    send_item(F_READ, KEY_W'($urandom), SLOT_W'(0));
    send_item(F_READ, KEY_W'($urandom), SLOT_W'(1));
    send_item(F_READ, KEY_W'($urandom), SLOT_W'(4));
    send_item(F_NOP, KEY_W'($urandom), SLOT_W'($urandom));
    send_item(F_CLEAR, KEY_W'($urandom), SLOT_W'($urandom));
    send_item(F_READ, KEY_W'($urandom), SLOT_W'(1));
    // ascending run down the right spine, last key walks off the tree
    for (int i = 1; i <= LEVELS + 1; i++)
      send_item(F_INSERT, KEY_W'(i), SLOT_W'($urandom));
    send_item(F_READ, KEY_W'($urandom), SLOT_W'(CAPACITY - 1));

    while (items_sent < ITEMS_TOTAL) begin
      sender_steady = ($urandom_range(4) == 0);
      send_item(F_CLEAR, KEY_W'($urandom), SLOT_W'($urandom));
      if ($urandom_range(2) == 0) begin
        // sorted run builds one deep spine and may overflow it
        base    = KEY_W'($signed($urandom) >>> 1);
        step    = $urandom_range(1, 1 << 20);
        len     = $urandom_range(LEVELS - 1, LEVELS + 3);
        falling = $urandom_range(1);
        for (int i = 0; i < len; i++)
          send_item(F_INSERT, falling ? base - KEY_W'(i * step) : base + KEY_W'(i * step),
                    SLOT_W'($urandom));
        n = $urandom_range(3, 10);
      end else begin
        n = $urandom_range(15, 70);
      end
      repeat (n) send_mixed();
    end
    in_ch.valid <= 1'b0;

    while (shadow.pending() != 0) @(posedge clk);
    repeat (2 * (LEVELS + 2)) @(posedge clk);
    if (shadow.mismatches == 0 && shadow.pending() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

  initial begin : watchdog
    #10ms;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/bsti_pkg.sv
rtl/bsti_in_if.sv
rtl/bsti_out_if.sv
rtl/bsti_ram.sv
rtl/bsti_walk.sv
rtl/array_bst_insert.sv
tb/tb.sv
